// ----- rtl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet frame checker package
// Shared types, codes, constants and the checksum text parser.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam logic [7:0]  TAB_CHAR     = 8'd9;
    localparam logic [7:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [10:0] MIN_FLOOR    = 11'd12;
    localparam int          TYPE_POS     = 4;
    localparam int          NUM_FIRST    = 5;
    localparam int          NUM_LAST     = 8;
    localparam int          SUM_FIRST    = 7;
    localparam int          CAT_START    = 9;
    localparam int          CAT_SKIP     = 10;

    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_RESYNC    = 4'd1,
        ERR_TOO_SHORT = 4'd2,
        ERR_START_A   = 4'd3,
        ERR_START_B   = 4'd4,
        ERR_STOP      = 4'd5,
        ERR_CHECKSUM  = 4'd6,
        ERR_CATEGORY  = 4'd7,
        ERR_TOO_LONG  = 4'd8
    } t_err_code;

    typedef enum logic [1:0] {
        CFG_START_A   = 2'd0,
        CFG_START_B   = 2'd1,
        CFG_HANDSHAKE = 2'd2,
        CFG_MIN_LEN   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_frame_in;

    typedef struct packed {
        logic [3:0]  verdict_code;
        logic        is_error;
        logic [7:0]  frame_type;
        logic [31:0] packet_number;
        logic [3:0]  category_length;
        logic [10:0] payload_start;
        logic [10:0] payload_stop;
    } t_frame_out;

    typedef struct packed {
        logic [7:0]  start_byte_a;
        logic [7:0]  start_byte_b;
        logic [7:0]  handshake_type;
        logic [10:0] min_frame_length;
    } t_cfg;

    typedef struct packed {
        logic        start_a_ok;
        logic        start_b_ok;
        logic        tab_seen;
        logic        first_zero;
        logic [7:0]  type_byte;
        logic [31:0] rx_number;
        logic [7:0]  sum;
        logic [7:0]  text_hi;
        logic [7:0]  text_lo;
    } t_frame_flags;

    // Bit 4 marks a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            d = {1'b1, 4'(c - 8'd48)};
        end else if (c >= 8'd97 && c <= 8'd102) begin
            d = {1'b1, 4'(c - 8'd87)};
        end else if (c >= 8'd65 && c <= 8'd70) begin
            d = {1'b1, 4'(c - 8'd55)};
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Two characters of hex text, read with leading blank, sign and early stop.
    function automatic logic [7:0] parse_hex2(input logic [7:0] c0, input logic [7:0] c1);
        logic [4:0] d0;
        logic [4:0] d1;
        logic [7:0] v;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        if (is_space(c0) || c0 == 8'd43) begin
            v = d1[4] ? {4'd0, d1[3:0]} : 8'd0;
        end else if (c0 == 8'd45) begin
            v = d1[4] ? (8'd0 - {4'd0, d1[3:0]}) : 8'd0;
        end else if (!d0[4]) begin
            v = 8'd0;
        end else if (!d1[4]) begin
            v = {4'd0, d0[3:0]};
        end else begin
            v = {d0[3:0], d1[3:0]};
        end
        return v;
    endfunction

endpackage

// ----- rtl/pfc_verdict.sv -----
// ----------------------------------------------------------------------------
// Packet frame checker verdict
// Ranks the frame checks on the final byte and forms the result and the
// next value of the local frame counter.
// ----------------------------------------------------------------------------
module pfc_verdict
    import pfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024,
    parameter int CATEGORY_MAX    = 15,
    parameter int POS_W           = 11
) (
    input  logic [POS_W-1:0] i_len,
    input  logic [POS_W-1:0] i_cat_count,
    input  t_frame_flags     i_flags,
    input  logic [7:0]       i_final_byte,
    input  t_cfg             i_cfg,
    input  logic [31:0]      i_local_count,
    output t_frame_out       o_result,
    output logic [31:0]      o_local_count
);

    logic [10:0] min_len;
    t_err_code   code;
    logic        count_up;
    logic [31:0] next_count;

    assign min_len = (i_cfg.min_frame_length < MIN_FLOOR) ? MIN_FLOOR
                                                          : i_cfg.min_frame_length;

    always_comb begin
        code                     = ERR_OK;
        count_up                 = 1'b1;
        next_count               = i_local_count;
        o_result.frame_type      = 8'd0;
        o_result.packet_number   = i_local_count;
        o_result.category_length = 4'd0;
        o_result.payload_start   = 11'd0;
        o_result.payload_stop    = 11'd0;
        if (32'(i_len) < 32'(min_len)) begin
            code     = ERR_TOO_SHORT;
            count_up = 1'b0;
        end else if (32'(i_len) > 32'(MAX_FRAME_BYTES)) begin
            code     = ERR_TOO_LONG;
            count_up = 1'b0;
        end else if (!i_flags.start_a_ok) begin
            code = ERR_START_A;
        end else if (!i_flags.start_b_ok) begin
            code = ERR_START_B;
        end else if (i_final_byte != NEWLINE_CHAR) begin
            code = ERR_STOP;
        end else if (i_flags.sum != parse_hex2(i_flags.text_hi, i_flags.text_lo)) begin
            code = ERR_CHECKSUM;
        end else begin
            o_result.frame_type = i_flags.type_byte;
            if (i_flags.type_byte == i_cfg.handshake_type) begin
                o_result.packet_number = i_flags.rx_number;
            end else if (i_flags.rx_number != i_local_count) begin
                next_count = i_flags.rx_number;
                code       = ERR_RESYNC;
            end
            if (i_cat_count == '0 || i_flags.first_zero
                    || 32'(i_cat_count) > 32'(CATEGORY_MAX)) begin
                code = ERR_CATEGORY;
            end else begin
                o_result.category_length = 4'(i_cat_count);
                o_result.payload_start   = i_flags.tab_seen
                    ? 11'(32'(i_cat_count) + 32'(CAT_SKIP)) : 11'(i_len);
                o_result.payload_stop    = 11'(32'(i_len) - 32'd2);
            end
        end
        if (count_up) begin
            next_count = next_count + 32'd1;
        end
        o_result.verdict_code = code;
        o_result.is_error     = (code != ERR_OK) && (code != ERR_RESYNC);
        o_local_count         = next_count;
    end

endmodule

// ----- rtl/packet_frame_checker_core.sv -----
// ----------------------------------------------------------------------------
// Packet frame checker core
// Takes one frame byte per transfer and gives one verdict per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless the input stalls; frames back to back
// with no gap. A final byte is registered on transfer and its verdict when
// processed; input stalls only while a final byte waits behind a held result.
// Reset (synchronous, active low) clears frame state, the local frame counter
// and config bytes, sets min length to MIN_FLOOR; no clearing pass is needed.
module packet_frame_checker_core
    import pfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024,
    parameter int CATEGORY_MAX    = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_frame_in   i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_frame_out  o_out_data
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);

    t_cfg             r_cfg;
    logic             r_in_valid;
    t_frame_in        r_in;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_td [3];
    logic [POS_W-1:0] r_cat;
    t_frame_flags     r_flags;
    logic [31:0]      r_local_count;
    logic             r_out_valid;
    t_frame_out       r_out;

    t_frame_flags     n_flags;
    logic [POS_W-1:0] n_cat;
    logic [POS_W-1:0] w_len;
    logic             w_proc;
    t_frame_out       w_result;
    logic [31:0]      w_local_count;
    logic [7:0]       w_b;

    assign w_proc     = r_in_valid && (!r_in.last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_proc;
    assign w_b        = r_in.data_byte;
    assign w_len      = r_pos + POS_W'(1);

    always_comb begin
        n_flags         = r_flags;
        n_cat           = r_cat;
        n_flags.text_hi = r_td[1];
        n_flags.text_lo = r_td[0];
        if (r_pos == POS_W'(0) && w_b == r_cfg.start_byte_a) begin
            n_flags.start_a_ok = 1'b1;
        end
        if (r_pos == POS_W'(1) && w_b == r_cfg.start_byte_b) begin
            n_flags.start_b_ok = 1'b1;
        end
        if (r_pos == POS_W'(TYPE_POS)) begin
            n_flags.type_byte = w_b;
        end
        if (r_pos >= POS_W'(NUM_FIRST) && r_pos <= POS_W'(NUM_LAST)) begin
            n_flags.rx_number = {r_flags.rx_number[23:0], w_b};
        end
        if (r_pos >= POS_W'(SUM_FIRST)) begin
            n_flags.sum = r_flags.sum + r_td[2];
        end
        if (r_pos >= POS_W'(CAT_START) && !r_flags.tab_seen) begin
            if (w_b == TAB_CHAR) begin
                n_flags.tab_seen = 1'b1;
            end else begin
                if (r_pos == POS_W'(CAT_START)) begin
                    n_flags.first_zero = (w_b == 8'd0);
                end
                if (r_cat < POS_W'(MAX_FRAME_BYTES)) begin
                    n_cat = r_cat + POS_W'(1);
                end
            end
        end
    end

    pfc_verdict #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CATEGORY_MAX    (CATEGORY_MAX),
        .POS_W           (POS_W)
    ) u_verdict (
        .i_len         (w_len),
        .i_cat_count   (n_cat),
        .i_flags       (n_flags),
        .i_final_byte  (w_b),
        .i_cfg         (r_cfg),
        .i_local_count (r_local_count),
        .o_result      (w_result),
        .o_local_count (w_local_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte_a     <= 8'd0;
            r_cfg.start_byte_b     <= 8'd0;
            r_cfg.handshake_type   <= 8'd0;
            r_cfg.min_frame_length <= MIN_FLOOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_A:   r_cfg.start_byte_a     <= i_cfg_data[7:0];
                CFG_START_B:   r_cfg.start_byte_b     <= i_cfg_data[7:0];
                CFG_HANDSHAKE: r_cfg.handshake_type   <= i_cfg_data[7:0];
                CFG_MIN_LEN:   r_cfg.min_frame_length <= i_cfg_data;
                default:       r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_td[0]       <= 8'd0;
            r_td[1]       <= 8'd0;
            r_td[2]       <= 8'd0;
            r_cat         <= '0;
            r_flags       <= '0;
            r_local_count <= 32'd0;
        end else if (w_proc) begin
            if (r_in.last_byte) begin
                r_pos         <= '0;
                r_td[0]       <= 8'd0;
                r_td[1]       <= 8'd0;
                r_td[2]       <= 8'd0;
                r_cat         <= '0;
                r_flags       <= '0;
                r_local_count <= w_local_count;
            end else begin
                r_td[0] <= w_b;
                r_td[1] <= r_td[0];
                r_td[2] <= r_td[1];
                r_cat   <= n_cat;
                r_flags <= n_flags;
                if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_verdict_from_final_byte: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_proc && r_in.last_byte)
    ) else $error("Result appeared without a final byte transfer.");

    a_length_errors_keep_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.last_byte && (w_result.verdict_code == ERR_TOO_SHORT
            || w_result.verdict_code == ERR_TOO_LONG)) |=> $stable(r_local_count)
    ) else $error("Length error changed the local frame counter.");

    a_position_saturates: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= 32'(MAX_FRAME_BYTES)
    ) else $error("Byte position ran past the frame limit.");

    a_stalled_result_kept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data))
    ) else $error("Stalled result was lost or overwritten.");

endmodule
